[rtl/assert_macros.svh]
// Assertion macros shared by the log ring RTL.
// Depends on clk_i and rst_ni being declared in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ldlr_pkg.sv]
// Package for the line-dropping log ring: action codes, state encoding, constants.
// No dependencies.
package ldlr_pkg;

  localparam int unsigned STORE_BYTES_DEF = 8 * 1024;
  localparam int unsigned MAX_PACKET      = 512;

  localparam int unsigned ACT_W  = 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 13;
  localparam int unsigned LEN_W  = 10;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH = 2'd0,
    ACT_TAKE = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

endpackage

[rtl/line_dropping_log_ring_top.sv]
// A result beat appears on done_o in the cycle after start is taken.
// One action per cycle, except a push that overflows the store; it
// keeps busy high while the tail walks to the next newline, one store entry a
// cycle through the memory read port.
// Reset: head and tail return to 0 and the chunk cap to 512; store contents are
// kept. The receiver cannot stall: each result beat lasts exactly one cycle.
// Circular log byte store that drops its oldest line on overflow.
// Depends on ldlr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module line_dropping_log_ring_top #(
  parameter int unsigned STORE_BYTES = ldlr_pkg::STORE_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [ldlr_pkg::ACT_W-1:0]    action_i,
  input  logic [ldlr_pkg::BYTE_W-1:0]   data_byte_i,
  input  logic [ldlr_pkg::POS_W-1:0]    read_index_i,
  input  logic                          cfg_we_i,
  input  logic [ldlr_pkg::LEN_W-1:0]    cfg_wdata_i,
  output logic                          done_o,
  output logic [ldlr_pkg::POS_W-1:0]    chunk_start_o,
  output logic [ldlr_pkg::LEN_W-1:0]    chunk_len_o,
  output logic                          was_empty_o,
  output logic [ldlr_pkg::BYTE_W-1:0]   read_data_o,
  output logic                          dropped_line_o
);

  localparam int unsigned AW = $clog2(STORE_BYTES);
  localparam int unsigned SW = AW + 1;
  localparam int unsigned LW = (SW > ldlr_pkg::LEN_W) ? SW : ldlr_pkg::LEN_W;
  localparam int unsigned CW = (SW > ldlr_pkg::POS_W) ? SW : ldlr_pkg::POS_W;
  localparam logic [AW-1:0] LAST_POS = AW'(STORE_BYTES - 1);
  localparam logic [ldlr_pkg::LEN_W-1:0] CAP_MAX = ldlr_pkg::LEN_W'(ldlr_pkg::MAX_PACKET);

  function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
    logic [AW-1:0] n;
    if (p == LAST_POS) n = '0;
    else               n = p + AW'(1);
    return n;
  endfunction

  ldlr_pkg::state_e  state_q, state_d;
  ldlr_pkg::action_e act;

  logic [AW-1:0] wpos_q, wpos_d;
  logic [AW-1:0] rpos_q, rpos_d;
  logic [ldlr_pkg::LEN_W-1:0] cap_q;

  logic accept;
  logic [AW-1:0] wpos_inc, rpos_inc;
  logic overflow, push_ovf;
  logic found_nl, walk_done;

  logic [ldlr_pkg::LEN_W-1:0] cap_eff;
  logic [SW-1:0] span;
  logic [LW-1:0] span_l;
  logic [ldlr_pkg::LEN_W-1:0] take_len;
  logic [LW-1:0] take_sum;
  logic [AW-1:0] take_end;
  logic idx_ok;

  logic [ldlr_pkg::BYTE_W-1:0] mem [STORE_BYTES];
  logic [ldlr_pkg::BYTE_W-1:0] mem_rdata_q;
  logic [AW-1:0] rd_addr;
  logic mem_we;

  logic done_q;
  logic [ldlr_pkg::POS_W-1:0] chunk_start_q;
  logic [ldlr_pkg::LEN_W-1:0] chunk_len_q;
  logic was_empty_q, dropped_q, rd_sel_q;

  assign act      = ldlr_pkg::action_e'(action_i);
  assign accept   = start && !busy;
  assign wpos_inc = next_pos(wpos_q);
  assign rpos_inc = next_pos(rpos_q);
  assign overflow = (wpos_inc == rpos_q);
  assign push_ovf = accept && (act == ldlr_pkg::ACT_PUSH) && overflow;

  // Walk: memory data belongs to the current tail candidate
  assign found_nl  = (mem_rdata_q == ldlr_pkg::NEWLINE_BYTE);
  assign walk_done = found_nl || (rpos_inc == wpos_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ldlr_pkg::ST_IDLE: begin
        if (push_ovf) state_d = ldlr_pkg::ST_WALK;
      end
      ldlr_pkg::ST_WALK: begin
        if (walk_done) state_d = ldlr_pkg::ST_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    busy = 1'b0;
    unique case (state_q)
      ldlr_pkg::ST_IDLE: busy = 1'b0;
      ldlr_pkg::ST_WALK: busy = 1'b1;
    endcase
  end

  // Clamp the chunk cap and size the contiguous span
  always_comb begin
    priority if (cap_q == '0)    cap_eff = ldlr_pkg::LEN_W'(1);
    else if (cap_q > CAP_MAX)    cap_eff = CAP_MAX;
    else                         cap_eff = cap_q;

    if (rpos_q > wpos_q) span = SW'(STORE_BYTES) - {1'b0, rpos_q};
    else                 span = {1'b0, wpos_q} - {1'b0, rpos_q};
    span_l = LW'(span);

    if (span_l > LW'(cap_eff)) take_len = cap_eff;
    else                       take_len = ldlr_pkg::LEN_W'(span_l);

    take_sum = LW'(rpos_q) + LW'(take_len);
    if (take_sum >= LW'(STORE_BYTES)) take_end = '0;
    else                              take_end = AW'(take_sum);
  end

  assign idx_ok = (CW'(read_index_i) < CW'(STORE_BYTES));

  // Head and tail updates
  always_comb begin
    wpos_d = wpos_q;
    rpos_d = rpos_q;
    if (busy) begin
      if (!found_nl) rpos_d = rpos_inc;
    end else if (accept) begin
      unique case (act)
        ldlr_pkg::ACT_PUSH: begin
          wpos_d = wpos_inc;
          if (overflow) rpos_d = rpos_inc;
        end
        ldlr_pkg::ACT_TAKE: rpos_d = take_end;
        ldlr_pkg::ACT_READ: ;
        ldlr_pkg::ACT_NONE: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ldlr_pkg::ST_IDLE;
      wpos_q  <= '0;
      rpos_q  <= '0;
      cap_q   <= CAP_MAX;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wpos_q  <= wpos_d;
      rpos_q  <= rpos_d;
      done_q  <= accept;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
    end
  end

  // Store: one write port for pushes, one registered read port shared by
  // read actions and the overflow walk
  assign mem_we  = accept && (act == ldlr_pkg::ACT_PUSH);
  assign rd_addr = (!busy && act == ldlr_pkg::ACT_READ) ? AW'(read_index_i) : rpos_inc;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wpos_q] <= data_byte_i;
    mem_rdata_q <= mem[rd_addr];
  end

  // Capture the result beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      chunk_start_q <= (act == ldlr_pkg::ACT_TAKE) ? ldlr_pkg::POS_W'(rpos_q) : '0;
      chunk_len_q   <= (act == ldlr_pkg::ACT_TAKE) ? take_len : '0;
      was_empty_q   <= (rpos_q == wpos_q);
      dropped_q     <= (act == ldlr_pkg::ACT_PUSH) && overflow;
      rd_sel_q      <= (act == ldlr_pkg::ACT_READ) && idx_ok;
    end
  end

  assign done_o         = done_q;
  assign chunk_start_o  = chunk_start_q;
  assign chunk_len_o    = chunk_len_q;
  assign was_empty_o    = was_empty_q;
  assign dropped_line_o = dropped_q;
  assign read_data_o    = rd_sel_q ? mem_rdata_q : '0;

  // Checks
  `ASSERT_NXT(a_ovf_walks, push_ovf, busy, "overflow push did not start the walk")
  `ASSERT_IMP(a_walk_tail, busy, rpos_q != wpos_q, "walk tail reached head while busy")
  `ASSERT_NXT(a_beat_after_accept, accept, done_o, "missing result beat")
  `ASSERT_NXT(a_no_extra_beat, !accept, !done_o, "result beat without an accepted action")
  `ASSERT_IMP(a_drop_walks, done_o && dropped_line_o, busy, "dropped line without walk")

endmodule
